FILE: src/c2f_pkg.sv
// ----------------------------------------------------------------------------
// c2f_pkg
// Shared types and constants of the chunk-to-frame rebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package c2f_pkg;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [63:0] chunk_timestamp;
        logic        chunk_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_last;
        logic        fill_ok;
        logic [63:0] frame_timestamp;
        logic        overflow_seen;
    } out_item_t;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_FILL = 1'b1;

    localparam logic REG_FRAME_LENGTH     = 1'b0;
    localparam logic REG_BYTES_PER_SAMPLE = 1'b1;

    localparam int CFG_DATA_W    = 7;
    localparam int FRAME_LEN_W   = 7;
    localparam int BPS_W         = 5;
    localparam int DIVISOR_W     = 5;

    // 1000 / 48 reduced: samples * 125 / 6 microseconds
    localparam logic [6:0] US_NUM = 7'd125;
    localparam int         US_DEN = 6;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 7'd64;
    localparam logic [BPS_W-1:0]       BPS_RESET       = 5'd2;

endpackage

`default_nettype wire

FILE: src/c2f_ram.sv
// ----------------------------------------------------------------------------
// c2f_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module c2f_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/c2f_div.sv
// ----------------------------------------------------------------------------
// c2f_div
// Restoring divider by a narrow divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module c2f_div #(
    parameter int QW = 20
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [QW-1:0]                   dividend,
    input  wire logic [c2f_pkg::DIVISOR_W-1:0]   divisor,
    output logic                                 done,
    output logic      [QW-1:0]                   quotient
);
    import c2f_pkg::*;

    localparam int CNTW = $clog2(QW + 1);

    logic [QW-1:0]        quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   trial;
    logic                 q_bit;
    logic [DIVISOR_W-1:0] rem_next;

    always_comb begin
        trial = {rem_reg, quo_reg[QW-1]};
        q_bit = (trial >= {1'b0, div_reg});
        if (q_bit) begin
            rem_next = DIVISOR_W'(trial - {1'b0, div_reg});
        end else begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNTW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[QW-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/chunk_to_frame_rebuffer.sv
// ----------------------------------------------------------------------------
// chunk_to_frame_rebuffer
// Byte ring rebuffer for timestamped chunks, emitting fixed-length frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transfer is either a chunk byte (req_type push) or a
//   fill request. Pushes produce no result.
//   m_* channel: a fill yields frame_length results (0 read as 1, at most
//   MAX_FRAME), the last one flagged, or a single failure result when too
//   little data is held. A failed fill shows its result the cycle after
//   the request. A good fill first reads the head chunk's stamp and size.
//   Unless offset or stamp is zero, the offset is then divided by the
//   bytes_per_sample value on a serial divider and the samples are scaled
//   by 125 / 6 with a reciprocal multiply. Each frame byte then passes
//   ring read, output load and output transfer.
//   The block works on one request at a time; s_ready is low until the last
//   result of a fill has been taken. A stalled receiver holds the output
//   register and the block waits.
//   Reset clears all pointers, counters and the overflow flag and loads
//   frame_length 64 and bytes_per_sample 2; memories are not cleared.
//   Configuration writes belong in idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_to_frame_rebuffer #(
    parameter int BYTE_DEPTH  = 4096,
    parameter int CHUNK_DEPTH = 64,
    parameter int MAX_FRAME   = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire c2f_pkg::in_item_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output c2f_pkg::out_item_t                      m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic                               cfg_index,
    input  wire logic [c2f_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import c2f_pkg::*;

    localparam int BW  = $clog2(BYTE_DEPTH);
    localparam int CW  = $clog2(CHUNK_DEPTH);
    localparam int SW  = $clog2(BYTE_DEPTH + 2);
    localparam int CCW = $clog2(CHUNK_DEPTH + 1);
    localparam int LW  = $clog2(MAX_FRAME + 1);
    localparam int PW  = SW + 7;
    // x / 6 == (x * RECIP) >> RK for every x below 2**PW
    localparam int RK  = PW + 3;
    localparam longint unsigned RECIP = ((64'd1 << RK) + 64'(US_DEN - 1)) / 64'(US_DEN);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_STAMP = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_SCALE = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_LD    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]             state_reg;
    logic [FRAME_LEN_W-1:0] frame_len_reg;
    logic [BPS_W-1:0]       bps_reg;

    logic [BW-1:0]  byte_wr_ptr_reg;
    logic [BW-1:0]  byte_rd_ptr_reg;
    logic [BW-1:0]  wr_addr_reg;
    logic [SW-1:0]  committed_reg;
    logic [CW-1:0]  chunk_wr_ptr_reg;
    logic [CW-1:0]  chunk_rd_ptr_reg;
    logic [CCW-1:0] chunk_cnt_reg;
    logic [SW-1:0]  head_off_reg;
    logic [SW-1:0]  open_reg;
    logic           ovf_reg;

    logic [LW-1:0]  len_reg;
    logic [LW-1:0]  cnt_reg;
    logic [63:0]    stamp_reg;
    logic [PW-1:0]  prod_reg;
    logic [PW-1:0]  us_reg;
    logic           out_valid_reg;
    out_item_t      out_reg;

    // Memory ports
    logic [7:0]     ring_rdata;
    logic [63:0]    stamp_rdata;
    logic [SW-1:0]  size_rdata;
    logic           ring_we;
    logic           stamp_we;
    logic           size_we;

    // Divider
    logic                 div_start;
    logic                 div_done;
    logic [SW-1:0]        div_quotient;
    logic [2*PW:0]        scaled;

    logic           in_xfer;
    logic           push;
    logic           fill;
    logic           out_xfer;
    logic [LW-1:0]  len_eff;
    logic [SW-1:0]  avail;
    logic           fill_fail;
    logic           room;
    logic           open_sat;
    logic [SW-1:0]  size_now;
    logic           fits;
    logic [BW-1:0]  wr_addr_inc;
    logic [BW-1:0]  byte_rd_inc;
    logic [CW-1:0]  chunk_wr_inc;
    logic [CW-1:0]  chunk_rd_inc;
    logic [SW-1:0]  head_off_inc;
    logic [BPS_W-1:0] bps_eff;

    assign s_ready  = (state_reg == S_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign push     = in_xfer && (s_data.req_type == REQ_PUSH);
    assign fill     = in_xfer && (s_data.req_type == REQ_FILL);
    assign out_xfer = out_valid_reg && m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        if (frame_len_reg == '0) begin
            len_eff = LW'(1);
        end else if (frame_len_reg > FRAME_LEN_W'(MAX_FRAME)) begin
            len_eff = LW'(MAX_FRAME);
        end else begin
            len_eff = LW'(frame_len_reg);
        end
        bps_eff = (bps_reg == '0) ? BPS_W'(1) : bps_reg;
    end

    assign avail     = committed_reg - head_off_reg;
    assign fill_fail = (chunk_cnt_reg == '0) || (avail < SW'(len_eff));

    // Push side: bytes land only while the ring has room; size counts on to BYTE_DEPTH + 1
    assign room     = ((SW+1)'(committed_reg) + (SW+1)'(open_reg)) < (SW+1)'(BYTE_DEPTH);
    assign open_sat = (open_reg <= SW'(BYTE_DEPTH));
    assign size_now = open_sat ? (open_reg + SW'(1)) : open_reg;
    assign fits     = (((SW+1)'(committed_reg) + (SW+1)'(size_now)) <= (SW+1)'(BYTE_DEPTH))
                      && (chunk_cnt_reg < CCW'(CHUNK_DEPTH));

    assign wr_addr_inc  = (wr_addr_reg == BW'(BYTE_DEPTH - 1)) ? '0 : wr_addr_reg + BW'(1);
    assign byte_rd_inc  = (byte_rd_ptr_reg == BW'(BYTE_DEPTH - 1)) ? '0
                          : byte_rd_ptr_reg + BW'(1);
    assign chunk_wr_inc = (chunk_wr_ptr_reg == CW'(CHUNK_DEPTH - 1)) ? '0
                          : chunk_wr_ptr_reg + CW'(1);
    assign chunk_rd_inc = (chunk_rd_ptr_reg == CW'(CHUNK_DEPTH - 1)) ? '0
                          : chunk_rd_ptr_reg + CW'(1);
    assign head_off_inc = head_off_reg + SW'(1);

    assign ring_we  = push && room;
    assign stamp_we = push && (open_reg == '0) && (chunk_cnt_reg < CCW'(CHUNK_DEPTH));
    assign size_we  = push && s_data.chunk_end && fits;

    // offset / bytes_per_sample only when both offset and stamp are nonzero
    assign div_start = (state_reg == S_STAMP) && (head_off_reg != '0) && (stamp_rdata != '0);

    // samples * 125 / 6 via reciprocal multiply
    assign scaled = (2*PW+1)'(prod_reg) * (2*PW+1)'(RECIP);

    c2f_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (wr_addr_reg),
        .wdata (s_data.data_byte),
        .raddr (byte_rd_ptr_reg),
        .rdata (ring_rdata)
    );

    c2f_ram #(.WIDTH(64), .DEPTH(CHUNK_DEPTH)) u_stamp (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (chunk_wr_ptr_reg),
        .wdata (s_data.chunk_timestamp),
        .raddr (chunk_rd_ptr_reg),
        .rdata (stamp_rdata)
    );

    c2f_ram #(.WIDTH(SW), .DEPTH(CHUNK_DEPTH)) u_size (
        .aclk  (aclk),
        .we    (size_we),
        .waddr (chunk_wr_ptr_reg),
        .wdata (size_now),
        .raddr (chunk_rd_ptr_reg),
        .rdata (size_rdata)
    );

    c2f_div #(.QW(SW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (head_off_reg),
        .divisor  (DIVISOR_W'(bps_eff)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= FRAME_LEN_RESET;
            bps_reg       <= BPS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:     frame_len_reg <= cfg_wdata[FRAME_LEN_W-1:0];
                REG_BYTES_PER_SAMPLE: bps_reg       <= cfg_wdata[BPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and buffer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            byte_wr_ptr_reg  <= '0;
            byte_rd_ptr_reg  <= '0;
            wr_addr_reg      <= '0;
            committed_reg    <= '0;
            chunk_wr_ptr_reg <= '0;
            chunk_rd_ptr_reg <= '0;
            chunk_cnt_reg    <= '0;
            head_off_reg     <= '0;
            open_reg         <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            len_reg          <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (push) begin
                        if (s_data.chunk_end) begin
                            open_reg <= '0;
                            if (fits) begin
                                chunk_wr_ptr_reg <= chunk_wr_inc;
                                chunk_cnt_reg    <= chunk_cnt_reg + CCW'(1);
                                committed_reg    <= committed_reg + size_now;
                                byte_wr_ptr_reg  <= wr_addr_inc;
                                wr_addr_reg      <= wr_addr_inc;
                            end else begin
                                // chunk dropped whole
                                ovf_reg     <= 1'b1;
                                wr_addr_reg <= byte_wr_ptr_reg;
                            end
                        end else if (open_sat) begin
                            open_reg    <= size_now;
                            wr_addr_reg <= wr_addr_inc;
                        end
                    end else if (fill) begin
                        len_reg <= len_eff;
                        cnt_reg <= '0;
                        if (fill_fail) begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end else begin
                            state_reg <= S_SRD;
                        end
                    end
                end
                S_SRD:   state_reg <= S_STAMP;
                S_STAMP: state_reg <= div_start ? S_DIV : S_RD;
                S_DIV:   if (div_done) begin
                    state_reg <= S_SCALE;
                end
                S_SCALE: state_reg <= S_ADD;
                S_ADD:   state_reg <= S_RD;
                S_RD:    state_reg <= S_LD;
                S_LD: begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT: begin
                    if (out_xfer) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= out_reg.frame_last ? S_IDLE : S_RD;
                        if (out_reg.fill_ok) begin
                            cnt_reg         <= cnt_reg + LW'(1);
                            byte_rd_ptr_reg <= byte_rd_inc;
                            if (head_off_inc >= size_rdata) begin
                                committed_reg    <= committed_reg - size_rdata;
                                chunk_rd_ptr_reg <= chunk_rd_inc;
                                chunk_cnt_reg    <= chunk_cnt_reg - CCW'(1);
                                head_off_reg     <= '0;
                            end else begin
                                head_off_reg <= head_off_inc;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_STAMP) begin
            stamp_reg <= stamp_rdata;
        end else if (state_reg == S_ADD) begin
            stamp_reg <= stamp_reg + 64'(us_reg);
        end
        if ((state_reg == S_DIV) && div_done) begin
            prod_reg <= PW'(div_quotient) * PW'(US_NUM);
        end
        if (state_reg == S_SCALE) begin
            us_reg <= PW'(scaled >> RK);
        end
        if (fill && fill_fail) begin
            out_reg.out_byte        <= '0;
            out_reg.frame_last      <= 1'b1;
            out_reg.fill_ok         <= 1'b0;
            out_reg.frame_timestamp <= '0;
            out_reg.overflow_seen   <= ovf_reg;
        end else if (state_reg == S_LD) begin
            out_reg.out_byte        <= ring_rdata;
            out_reg.frame_last      <= (LW'(cnt_reg + LW'(1)) == len_reg);
            out_reg.fill_ok         <= 1'b1;
            out_reg.frame_timestamp <= stamp_reg;
            out_reg.overflow_seen   <= ovf_reg;
        end
    end

    a_chunk_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        chunk_cnt_reg <= CCW'(CHUNK_DEPTH))
        else $error("chunk count beyond table depth");

    a_committed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        committed_reg <= SW'(BYTE_DEPTH))
        else $error("committed bytes beyond ring depth");

    a_fail_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.fill_ok) |-> out_reg.frame_last)
        else $error("failed fill result not marked last");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !s_ready)
        else $error("input accepted while a result is pending");

    a_head_needs_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_off_reg != '0) |-> (chunk_cnt_reg != '0))
        else $error("head offset without a held chunk");

endmodule

`default_nettype wire

FILE: test/c2f_frame_checker.sv
// ----------------------------------------------------------------------------
// c2f_frame_checker
// Watches both channels of the rebuffer, keeps a shadow of its byte ring and
// chunk table, predicts every frame byte and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2f_frame_checker #(
    parameter int BYTE_DEPTH  = 4096,
    parameter int CHUNK_DEPTH = 64,
    parameter int MAX_FRAME   = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire c2f_pkg::in_item_t              s_data,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire c2f_pkg::out_item_t             m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_index,
    input  wire logic [c2f_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                  fail_count,
    output int                                  pending_frames,
    output int                                  frames_seen,
    output int                                  good_frames
);
    import c2f_pkg::*;

    logic [7:0]  ring_shadow [BYTE_DEPTH];
    logic [63:0] stamp_shadow [CHUNK_DEPTH];
    int unsigned size_shadow [CHUNK_DEPTH];
    int unsigned wr_ptr, rd_ptr, held_bytes, chunk_wr, chunk_rd, chunks_held;
    int unsigned head_ofs, open_size;
    logic        ovf_sticky;
    logic [6:0]  frame_len_reg;
    logic [4:0]  bps_reg;
    out_item_t   frame_bytes_q [$];

    function automatic logic [63:0] head_stamp(int unsigned ofs, logic [63:0] base);
        int unsigned bps;
        logic [63:0] samples;
        bps = (bps_reg == 0) ? 1 : bps_reg;
        if (ofs == 0 || base == 0) return base;
        samples = ofs / bps;
        return base + samples * 64'd1000 / 64'd48;
    endfunction

    task automatic take_byte(in_item_t it);
        int unsigned sz;
        if (open_size == 0 && chunks_held < CHUNK_DEPTH)
            stamp_shadow[chunk_wr] = it.chunk_timestamp;
        if (held_bytes + open_size < BYTE_DEPTH)
            ring_shadow[(wr_ptr + open_size) % BYTE_DEPTH] = it.data_byte;
        if (open_size <= BYTE_DEPTH) open_size++;
        if (!it.chunk_end) return;
        sz = open_size;
        open_size = 0;
        if (held_bytes + sz <= BYTE_DEPTH && chunks_held < CHUNK_DEPTH) begin
            size_shadow[chunk_wr] = sz;
            chunk_wr = (chunk_wr + 1) % CHUNK_DEPTH;
            chunks_held++;
            held_bytes += sz;
            wr_ptr = (wr_ptr + sz) % BYTE_DEPTH;
        end else begin
            ovf_sticky = 1'b1;
        end
    endtask

    task automatic build_frame();
        int unsigned len;
        logic [63:0] st;
        out_item_t r;
        len = (frame_len_reg == 0) ? 1 : frame_len_reg;
        if (len > MAX_FRAME) len = MAX_FRAME;
        pending_frames++;
        if (chunks_held == 0 || held_bytes - head_ofs < len) begin
            r = '{out_byte: 8'd0, frame_last: 1'b1, fill_ok: 1'b0,
                  frame_timestamp: 64'd0, overflow_seen: ovf_sticky};
            frame_bytes_q.insert(frame_bytes_q.size(), r);
            return;
        end
        st = head_stamp(head_ofs, stamp_shadow[chunk_rd]);
        for (int unsigned i = 0; i < len; i++) begin
            r = '{out_byte: ring_shadow[rd_ptr], frame_last: (i + 1 == len),
                  fill_ok: 1'b1, frame_timestamp: st, overflow_seen: ovf_sticky};
            frame_bytes_q.insert(frame_bytes_q.size(), r);
            rd_ptr = (rd_ptr + 1) % BYTE_DEPTH;
            head_ofs++;
            if (head_ofs >= size_shadow[chunk_rd]) begin
                held_bytes -= size_shadow[chunk_rd];
                chunk_rd = (chunk_rd + 1) % CHUNK_DEPTH;
                chunks_held--;
                head_ofs = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            wr_ptr = 0; rd_ptr = 0; held_bytes = 0; chunk_wr = 0; chunk_rd = 0;
            chunks_held = 0; head_ofs = 0; open_size = 0; ovf_sticky = 1'b0;
            frame_len_reg = FRAME_LEN_RESET;
            bps_reg = BPS_RESET;
            frame_bytes_q.delete();
            fail_count = 0;
            pending_frames = 0;
            frames_seen = 0;
            good_frames = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_FRAME_LENGTH) frame_len_reg = cfg_wdata[6:0];
                else bps_reg = cfg_wdata[4:0];
            end
            // output side first: a result never belongs to a request in this cycle
            if (m_valid && m_ready) begin
                if (frame_bytes_q.size() == 0) begin
                    $error("unexpected result transfer: %p", m_data);
                    fail_count = fail_count + 1;
                end else begin
                    want = frame_bytes_q[0];
                    frame_bytes_q.delete(0);
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte,
                               m_data.out_byte);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b", want.frame_last,
                               m_data.frame_last);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.fill_ok !== want.fill_ok) begin
                        $error("fill_ok: expected %0b, got %0b", want.fill_ok,
                               m_data.fill_ok);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.frame_timestamp !== want.frame_timestamp) begin
                        $error("frame_timestamp: expected %0d, got %0d",
                               want.frame_timestamp, m_data.frame_timestamp);
                        fail_count = fail_count + 1;
                    end
                    if (m_data.overflow_seen !== want.overflow_seen) begin
                        $error("overflow_seen: expected %0b, got %0b",
                               want.overflow_seen, m_data.overflow_seen);
                        fail_count = fail_count + 1;
                    end
                    if (want.frame_last) begin
                        pending_frames--;
                        frames_seen++;
                        if (want.fill_ok) good_frames++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_PUSH) take_byte(s_data);
                else build_frame();
            end
        end
    end

    final begin
        if (frame_bytes_q.size() != 0)
            $error("%0d expected results never arrived", frame_bytes_q.size());
    end

endmodule

`default_nettype wire

FILE: test/tb_chunk_to_frame_rebuffer.sv
// ----------------------------------------------------------------------------
// tb_chunk_to_frame_rebuffer
// Drives chunk bytes and fill requests into the rebuffer under several
// idling phases and register settings; a checker module scores the frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_chunk_to_frame_rebuffer;
    import c2f_pkg::*;

    localparam int  BYTE_DEPTH  = 4096;
    localparam int  CHUNK_DEPTH = 64;
    localparam int  MAX_FRAME   = 64;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = REG_FRAME_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count, pending_frames, frames_seen, good_frames;
    int                    send_idle_pct, recv_stall_pct;
    int                    items_sent;
    longint                cycle_count = 0;
    logic [63:0]           cur_stamp;
    bit                    chunk_open;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    chunk_to_frame_rebuffer #(
        .BYTE_DEPTH(BYTE_DEPTH), .CHUNK_DEPTH(CHUNK_DEPTH), .MAX_FRAME(MAX_FRAME)
    ) i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    c2f_frame_checker #(
        .BYTE_DEPTH(BYTE_DEPTH), .CHUNK_DEPTH(CHUNK_DEPTH), .MAX_FRAME(MAX_FRAME)
    ) i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .cfg_wr_en, .cfg_index, .cfg_wdata, .fail_count,
        .pending_frames, .frames_seen, .good_frames
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("chunk_to_frame_rebuffer test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays up between back-to-back items; it drops on idle cycles and
    // at the start of a drain
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic push_byte(logic [7:0] b, logic [63:0] st, bit last_byte);
        in_item_t it;
        it = '{req_type: REQ_PUSH, data_byte: b, chunk_timestamp: st,
               chunk_end: last_byte};
        send_item(it);
    endtask

    task automatic fill_req();
        in_item_t it;
        it = '{req_type: REQ_FILL, data_byte: 8'($urandom),
               chunk_timestamp: {$urandom, $urandom}, chunk_end: 1'($urandom)};
        send_item(it);
    endtask

    task automatic push_chunk(int unsigned len, logic [63:0] st);
        for (int unsigned i = 0; i < len; i++)
            push_byte(8'($urandom), st, i + 1 == len);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_frames != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int unsigned n_items, int idle, int stall);
        in_item_t it;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int unsigned k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 12) begin
                fill_req();
            end else if ($urandom_range(99) < 3) begin
                // junk-ish byte with random stamp and end flag
                it = '{req_type: REQ_PUSH, data_byte: 8'($urandom),
                       chunk_timestamp: {$urandom, $urandom}, chunk_end: 1'($urandom)};
                chunk_open = !it.chunk_end;
                send_item(it);
            end else begin
                if (!chunk_open) begin
                    case ($urandom_range(3))
                        0: cur_stamp = 64'd0;
                        1: cur_stamp = {$urandom, $urandom};
                        2: cur_stamp = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
                        default: cur_stamp = 64'($urandom);
                    endcase
                end
                chunk_open = ($urandom_range(99) >= 8);
                push_byte(8'($urandom), cur_stamp, !chunk_open);
            end
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        chunk_open = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty fill, stamps at extremes, frames spanning chunks
        fill_req();
        write_reg(REG_FRAME_LENGTH, 7'd3);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd0);
        push_chunk(2, 64'd0);
        push_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_byte(8'h00, 64'd5, 1'b1);
        fill_req();
        fill_req();
        push_chunk(4, 64'hFFFF_FFFF_FFFF_FFFF);
        fill_req();
        fill_req();
        write_reg(REG_FRAME_LENGTH, 7'd0);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd31);
        fill_req();
        fill_req();
        write_reg(REG_FRAME_LENGTH, 7'd127);
        push_chunk(5, 64'h5555_AAAA_0000_0001);
        fill_req();

        // overflow: many single-byte chunks exceed the chunk table
        write_reg(REG_FRAME_LENGTH, 7'd64);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd16);
        for (int i = 0; i < CHUNK_DEPTH + 4; i++) push_chunk(1, 64'(i + 1));
        repeat (4) fill_req();
        write_reg(REG_FRAME_LENGTH, 7'd1);
        repeat (12) fill_req();

        // random phases
        write_reg(REG_FRAME_LENGTH, 7'd8);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd2);
        random_phase(75, 0, 0);
        write_reg(REG_FRAME_LENGTH, 7'd1);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd1);
        random_phase(75, 50, 0);
        send_idle_pct = 0;
        drain();  // sender holds off until every result is back
        write_reg(REG_FRAME_LENGTH, 7'd64);
        write_reg(REG_BYTES_PER_SAMPLE, 5'd16);
        random_phase(80, 0, 50);
        write_reg(REG_FRAME_LENGTH, 7'($urandom_range(1, 20)));
        write_reg(REG_BYTES_PER_SAMPLE, 5'($urandom_range(1, 16)));
        random_phase(75, 13, 13);

        recv_stall_pct = 0;
        drain();
        $display("sent %0d items; %0d frames checked, %0d complete", items_sent,
                 frames_seen, good_frames);
        $display("register extremes, chunk table overflow, four idling phases");
        if (fail_count == 0) begin
            $display("chunk_to_frame_rebuffer test passed");
        end else begin
            $display("chunk_to_frame_rebuffer test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
